FILE: rtl/q16_16_fixed_point_alu_top_macros.svh
// Assertion macros for the Q16.16 fixed-point ALU.
`ifndef Q16_16_FIXED_POINT_ALU_TOP_MACROS_SVH
`define Q16_16_FIXED_POINT_ALU_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define Q16_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define Q16_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define Q16_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define Q16_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/q16alu_pkg.sv
// Types and constants shared by the Q16.16 fixed-point ALU modules.
package q16alu_pkg;

  localparam int DATA_W     = 32;
  localparam int SQRT_ITERS = 16;
  localparam logic [DATA_W-1:0] SQRT_BIT0 = 32'h4000_0000;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_NEG   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_TRUNC = 3'd5,
    OP_ROUND = 3'd6,
    OP_SQRT  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_SQRT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic div_step;
    logic sqrt_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic b_zero;
  } dp_status_t;

endpackage

FILE: rtl/q16alu_if.sv
// Valid/ready channel interfaces for operand and result transfers.
interface q16alu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, output op, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input op, input operand_a, input operand_b, output ready);
endinterface

interface q16alu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic               div_by_zero;
  logic               overflow;

  modport source (output valid, output result, output div_by_zero, output overflow,
                  input ready);
  modport sink   (input valid, input result, input div_by_zero, input overflow,
                  output ready);
endinterface

FILE: rtl/q16alu_ctrl.sv
// Sequencing state machine of the fixed-point ALU: handshakes and iteration count.
module q16alu_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  q16alu_pkg::dp_status_t  status,
  output q16alu_pkg::dp_cmd_t     cmd
);
  import q16alu_pkg::*;

  localparam int DW = DATA_W + FRAC_BITS;
  localparam int CW = $clog2(DW);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        if (status.op == OP_DIV && !status.b_zero) begin
          cnt_nxt   = CW'(DW - 1);
          state_nxt = S_DIV;
        end else if (status.op == OP_SQRT) begin
          cnt_nxt   = CW'(SQRT_ITERS - 1);
          state_nxt = S_SQRT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_DONE;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/q16alu_dp.sv
// Datapath of the fixed-point ALU: operand regs, multiplier, divider, root, result mux.
module q16alu_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  q16alu_pkg::dp_cmd_t     cmd,
  output q16alu_pkg::dp_status_t  status,
  input  logic [2:0]              in_op,
  input  logic signed [31:0]      in_a,
  input  logic signed [31:0]      in_b,
  output logic signed [31:0]      out_result,
  output logic                    out_div_by_zero,
  output logic                    out_overflow
);
  import q16alu_pkg::*;

  localparam int DW = DATA_W + FRAC_BITS;
  localparam logic [DATA_W:0] HALF = (DATA_W+1)'(1) << (FRAC_BITS - 1);

  op_t                      op_r, op_nxt;
  logic signed [DATA_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic signed [63:0]       prod_r, prod_nxt;
  logic [DATA_W-1:0]        rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [DW-1:0]            dvd_r, dvd_nxt;
  logic [DATA_W-1:0]        val_r, val_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic signed [DATA_W-1:0] res_r, res_nxt;
  logic                     dz_r, dz_nxt, ovf_r, ovf_nxt;

  logic [DATA_W-1:0]        mag_a, mag_b, trunc_mag, round_mag, mag_sel, root_bit;
  logic [DATA_W:0]          trial, round_sum;
  logic                     trial_ge, sqrt_ge, q_neg, q_hi_nz;
  logic signed [63:0]       shifted;

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    dvd_r  <= dvd_nxt;
    val_r  <= val_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    res_r  <= res_nxt;
    dz_r   <= dz_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign mag_a     = a_r[DATA_W-1] ? (~a_r + 1'b1) : a_r;
  assign mag_b     = b_r[DATA_W-1] ? (~b_r + 1'b1) : b_r;
  assign trial     = {rem_r, dvd_r[DW-1]};
  assign trial_ge  = trial >= {1'b0, dsr_r};
  assign root_bit  = root_r + bit_r;
  assign sqrt_ge   = val_r >= root_bit;
  assign trunc_mag = mag_a >> FRAC_BITS;
  assign round_sum = {1'b0, mag_a} + HALF;
  assign round_mag = DATA_W'(round_sum >> FRAC_BITS);
  assign mag_sel   = (op_r == OP_TRUNC) ? trunc_mag : round_mag;
  assign shifted   = prod_r >>> FRAC_BITS;
  assign q_neg     = a_r[DATA_W-1] ^ b_r[DATA_W-1];
  assign q_hi_nz   = |dvd_r[DW-1:DATA_W];

  assign status.op     = op_r;
  assign status.b_zero = (b_r == '0);

  always_comb begin
    op_nxt   = op_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    dvd_nxt  = dvd_r;
    val_nxt  = val_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    res_nxt  = res_r;
    dz_nxt   = dz_r;
    ovf_nxt  = ovf_r;

    if (cmd.load) begin
      op_nxt = op_t'(in_op);
      a_nxt  = in_a;
      b_nxt  = in_b;
    end

    if (cmd.start) begin
      prod_nxt = 64'(a_r) * 64'(b_r);
      rem_nxt  = '0;
      dsr_nxt  = mag_b;
      dvd_nxt  = {mag_a, {FRAC_BITS{1'b0}}};
      val_nxt  = a_r;
      root_nxt = '0;
      bit_nxt  = SQRT_BIT0;
    end

    if (cmd.div_step) begin
      rem_nxt = trial_ge ? DATA_W'(trial - {1'b0, dsr_r}) : DATA_W'(trial);
      dvd_nxt = {dvd_r[DW-2:0], trial_ge};
    end

    if (cmd.sqrt_step) begin
      if (sqrt_ge) begin
        val_nxt  = val_r - root_bit;
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
    end

    if (cmd.emit) begin
      dz_nxt  = 1'b0;
      ovf_nxt = 1'b0;
      case (op_r)
        OP_ADD: res_nxt = a_r + b_r;
        OP_SUB: res_nxt = a_r - b_r;
        OP_NEG: res_nxt = -a_r;
        OP_MUL: begin
          res_nxt = shifted[DATA_W-1:0];
          ovf_nxt = !((&shifted[63:DATA_W-1]) || !(|shifted[63:DATA_W-1]));
        end
        OP_DIV: begin
          if (b_r == '0) begin
            dz_nxt = 1'b1;
            if (a_r[DATA_W-1])   res_nxt = 32'sh8000_0000;
            else if (a_r != '0)  res_nxt = 32'sh7FFF_FFFF;
            else                 res_nxt = '0;
          end else if (q_neg) begin
            res_nxt = -dvd_r[DATA_W-1:0];
            ovf_nxt = q_hi_nz || (dvd_r[DATA_W-1] && (|dvd_r[DATA_W-2:0]));
          end else begin
            res_nxt = dvd_r[DATA_W-1:0];
            ovf_nxt = q_hi_nz || dvd_r[DATA_W-1];
          end
        end
        OP_TRUNC, OP_ROUND: begin
          res_nxt = a_r[DATA_W-1] ? -mag_sel : mag_sel;
        end
        OP_SQRT: begin
          if (!a_r[DATA_W-1] && a_r != '0) res_nxt = root_r << (FRAC_BITS / 2);
          else                             res_nxt = '0;
        end
        default: res_nxt = '0;
      endcase
    end
  end

  assign out_result      = res_r;
  assign out_div_by_zero = dz_r;
  assign out_overflow    = ovf_r;

endmodule

FILE: rtl/q16_16_fixed_point_alu_top.sv
// Each item is loaded in IDLE and prepared in START; a div with a nonzero divisor then runs the
// divider loop and a sqrt the root loop, and DONE waits for a free output register to take the result.
// One item at a time: a new item is accepted only after DONE has emitted the last one;
// the radix-2 divider loop gives one quotient bit a cycle and the root loop has 16 steps.
// A finished result waits in the output register while the next item is accepted.
// Synchronous active-low reset clears the state machine and the output valid.
`include "q16_16_fixed_point_alu_top_macros.svh"
module q16_16_fixed_point_alu_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  q16alu_in_if.sink      in_ch,
  q16alu_out_if.source   out_ch
);
  import q16alu_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  q16alu_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  q16alu_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .status          (status),
    .in_op           (in_ch.op),
    .in_a            (in_ch.operand_a),
    .in_b            (in_ch.operand_b),
    .out_result      (out_ch.result),
    .out_div_by_zero (out_ch.div_by_zero),
    .out_overflow    (out_ch.overflow)
  );

  // one item in flight: no second transfer right after the first
  `Q16_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken while busy")
  // result register only loaded when free or being drained
  `Q16_ASSERT_SAME(a_emit_slot, clk, rst_n, cmd.emit, !out_ch.valid || out_ch.ready, "result overwritten")
  `Q16_ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_ch.valid, "result not shown after emit")
  `Q16_ASSERT_SAME(a_idle_no_iter, clk, rst_n, in_ch.ready, !cmd.div_step && !cmd.sqrt_step, "iterating while idle")

endmodule

FILE: dv/q16_16_fixed_point_alu_top_test.sv
// Self-checking testbench for the Q16.16 fixed-point ALU: directed table, then random phases.
`timescale 1ns / 1ps
module q16_16_fixed_point_alu_top_test;
  import q16alu_pkg::*;

  localparam int FRAC             = 16;
  localparam int HALF_PERIOD      = 10;
  localparam int RESET_CYCLES     = 7;
  localparam int DIRECTED_ROWS    = 25;
  localparam int ITEMS_PER_PHASE  = 270;
  localparam int NUM_PHASES       = 4;
  localparam int HOLD_CYCLES      = 300;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int TAIL_CYCLES      = 60;
  localparam int MAX_REPORT_LINES = 100;
  localparam bit KNOWN            = 1'b1;
  localparam bit PREDICT          = 1'b0;

  typedef struct packed {
    logic [31:0] result;
    logic        div_by_zero;
    logic        overflow;
  } alu_result_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
    logic        known;
    alu_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  q16alu_in_if  in_ch();
  q16alu_out_if out_ch();

  q16_16_fixed_point_alu_top #(.FRAC_BITS(FRAC)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  alu_result_t pending_results[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_ADD,   32'h0001_0000, 32'h0001_0000, KNOWN,   '{32'h0002_0000, 1'b0, 1'b0}},
    '{OP_ADD,   32'h7FFF_FFFF, 32'h0000_0001, KNOWN,   '{32'h8000_0000, 1'b0, 1'b0}},
    '{OP_SUB,   32'h8000_0000, 32'h0000_0001, KNOWN,   '{32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{OP_NEG,   32'h8000_0000, 32'h1234_5678, KNOWN,   '{32'h8000_0000, 1'b0, 1'b0}},
    '{OP_NEG,   32'h0000_0000, 32'hFFFF_FFFF, KNOWN,   '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_MUL,   32'h0002_0000, 32'h0003_0000, KNOWN,   '{32'h0006_0000, 1'b0, 1'b0}},
    '{OP_MUL,   32'h7FFF_FFFF, 32'h7FFF_FFFF, PREDICT, '0},
    '{OP_MUL,   32'h8000_0000, 32'h8000_0000, KNOWN,   '{32'h0000_0000, 1'b0, 1'b1}},
    '{OP_MUL,   32'hFFFF_FFFF, 32'h0000_0001, PREDICT, '0},
    '{OP_DIV,   32'h0001_0000, 32'h0000_0000, KNOWN,   '{32'h7FFF_FFFF, 1'b1, 1'b0}},
    '{OP_DIV,   32'hFFFF_0000, 32'h0000_0000, KNOWN,   '{32'h8000_0000, 1'b1, 1'b0}},
    '{OP_DIV,   32'h0000_0000, 32'h0000_0000, KNOWN,   '{32'h0000_0000, 1'b1, 1'b0}},
    '{OP_DIV,   32'h8000_0000, 32'hFFFF_0000, KNOWN,   '{32'h8000_0000, 1'b0, 1'b1}},
    '{OP_DIV,   32'h8000_0000, 32'h0001_0000, PREDICT, '0},
    '{OP_DIV,   32'h0003_0000, 32'h0002_0000, KNOWN,   '{32'h0001_8000, 1'b0, 1'b0}},
    '{OP_DIV,   32'h7FFF_FFFF, 32'h0000_0001, PREDICT, '0},
    '{OP_TRUNC, 32'hFFFE_8000, 32'h0000_0000, KNOWN,   '{32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{OP_TRUNC, 32'h8000_0000, 32'h0000_0000, PREDICT, '0},
    '{OP_ROUND, 32'h0002_8000, 32'h0000_0000, KNOWN,   '{32'h0000_0003, 1'b0, 1'b0}},
    '{OP_ROUND, 32'hFFFD_8000, 32'h0000_0000, KNOWN,   '{32'hFFFF_FFFD, 1'b0, 1'b0}},
    '{OP_ROUND, 32'h7FFF_FFFF, 32'h0000_0000, PREDICT, '0},
    '{OP_SQRT,  32'h0004_0000, 32'h0000_0000, KNOWN,   '{32'h0002_0000, 1'b0, 1'b0}},
    '{OP_SQRT,  32'h8000_0000, 32'h0000_0000, KNOWN,   '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_SQRT,  32'h0000_0000, 32'h0000_0000, KNOWN,   '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_SQRT,  32'h7FFF_FFFF, 32'h0000_0000, PREDICT, '0}
  };

  function automatic logic [31:0] int_sqrt(logic [31:0] v);
    logic [31:0] root;
    logic [31:0] probe;
    logic [31:0] rem;
    root  = '0;
    probe = 32'h4000_0000;
    rem   = v;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic alu_result_t predict_alu(op_t op, logic [31:0] a, logic [31:0] b);
    alu_result_t r;
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    logic signed [63:0] prod;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] quo;
    logic [63:0] mag;
    r    = '0;
    sa   = {{32{a[31]}}, a};
    sb   = {{32{b[31]}}, b};
    ma   = a[31] ? -sa : sa;
    mb   = b[31] ? -sb : sb;
    case (op)
      OP_ADD: r.result = a + b;
      OP_SUB: r.result = a - b;
      OP_NEG: r.result = -a;
      OP_MUL: begin
        prod       = (sa * sb) >>> FRAC;
        r.result   = prod[31:0];
        r.overflow = !((&prod[63:31]) || !(|prod[63:31]));
      end
      OP_DIV: begin
        if (b == 0) begin
          r.div_by_zero = 1'b1;
          if (a[31]) r.result = 32'h8000_0000;
          else if (a != 0) r.result = 32'h7FFF_FFFF;
        end else begin
          quo = (ma << FRAC) / mb;
          if (a[31] ^ b[31]) begin
            r.result   = -quo[31:0];
            r.overflow = quo > 64'h8000_0000;
          end else begin
            r.result   = quo[31:0];
            r.overflow = quo > 64'h7FFF_FFFF;
          end
        end
      end
      OP_TRUNC: begin
        mag      = ma >> FRAC;
        r.result = a[31] ? -mag[31:0] : mag[31:0];
      end
      OP_ROUND: begin
        mag      = (ma + (64'd1 << (FRAC - 1))) >> FRAC;
        r.result = a[31] ? -mag[31:0] : mag[31:0];
      end
      default: begin
        if (!a[31] && a != 0) r.result = int_sqrt(a) << (FRAC / 2);
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(7))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'hFFFF_FFFF;
          3: return 32'h7FFF_FFFF;
          4: return 32'h8000_0000;
          5: return 32'h0001_0000;
          6: return 32'hFFFF_0000;
          default: return 32'h0000_8000;
        endcase
      end
      1, 2: return {{13{r[18]}}, r[18:0]};
      3: return {r[31:16], 16'h8000};
      4: return {{13{r[18]}}, r[18:16], 16'h0000};
      default: return r;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORT_LINES)
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_op(op_t op, logic [31:0] a, logic [31:0] b, alu_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(want);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_left = HOLD_CYCLES;
      hold_seen = hold_reqs;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    alu_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.result, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.result !== want.result)
          report_mismatch("result", out_ch.result, want.result);
        if (out_ch.div_by_zero !== want.div_by_zero)
          report_mismatch("div_by_zero", 32'(out_ch.div_by_zero), 32'(want.div_by_zero));
        if (out_ch.overflow !== want.overflow)
          report_mismatch("overflow", 32'(out_ch.overflow), 32'(want.overflow));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int send_pcts [NUM_PHASES] = '{0, 80, 0, 23};
    int recv_pcts [NUM_PHASES] = '{0, 0, 80, 23};
    op_t op;
    logic [31:0] a;
    logic [31:0] b;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct  = 23;
    recv_stall_pct = 23;
    foreach (directed_rows[i]) begin
      send_op(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
              directed_rows[i].known ? directed_rows[i].want :
              predict_alu(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b));
    end
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      // back-pressure: receiver holds off while operands keep coming
      if (ph == 0) hold_reqs++;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        op = op_t'($urandom_range(7));
        a  = rand_operand();
        b  = rand_operand();
        send_op(op, a, b, predict_alu(op, a, b));
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/q16alu_pkg.sv
rtl/q16alu_if.sv
rtl/q16alu_ctrl.sv
rtl/q16alu_dp.sv
rtl/q16_16_fixed_point_alu_top.sv
dv/q16_16_fixed_point_alu_top_test.sv
